// ===== rtl/moi_pkg.sv =====
// Shared constants, control types and the arctangent table for the odometry integrator.
package moi_pkg;

   localparam int HEAD_BITS    = 16;
   localparam int IV_BITS      = 16;
   localparam int ANGLE_BITS   = 32;
   localparam int CORDIC_STEPS = 30;
   localparam int STEP_BITS    = $clog2(CORDIC_STEPS);

   localparam logic signed [31:0]        CORDIC_GAIN    = 32'sd652032874;
   localparam logic [IV_BITS-1:0]        INTERVAL_RESET = 16'd10000;

   typedef struct packed {
      logic issue;
      logic first;
      logic sub;
   } moi_mul_ctl_type;

   function automatic logic [ANGLE_BITS-1:0] atan_step(input logic [STEP_BITS-1:0] idx);
      logic [ANGLE_BITS-1:0] val;
      case (idx)
         5'd0:    val = 32'd536870912;
         5'd1:    val = 32'd316933406;
         5'd2:    val = 32'd167458907;
         5'd3:    val = 32'd85004756;
         5'd4:    val = 32'd42667331;
         5'd5:    val = 32'd21354465;
         5'd6:    val = 32'd10679838;
         5'd7:    val = 32'd5340245;
         5'd8:    val = 32'd2670163;
         5'd9:    val = 32'd1335087;
         5'd10:   val = 32'd667544;
         5'd11:   val = 32'd333772;
         5'd12:   val = 32'd166886;
         5'd13:   val = 32'd83443;
         5'd14:   val = 32'd41722;
         5'd15:   val = 32'd20861;
         5'd16:   val = 32'd10430;
         5'd17:   val = 32'd5215;
         5'd18:   val = 32'd2608;
         5'd19:   val = 32'd1304;
         5'd20:   val = 32'd652;
         5'd21:   val = 32'd326;
         5'd22:   val = 32'd163;
         5'd23:   val = 32'd81;
         5'd24:   val = 32'd41;
         5'd25:   val = 32'd20;
         5'd26:   val = 32'd10;
         5'd27:   val = 32'd5;
         5'd28:   val = 32'd3;
         5'd29:   val = 32'd1;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/moi_channels.sv =====
// Valid/ready channel interfaces for requests, responses and the interval register.
interface moi_req_if #(parameter int SPEED_BITS = 16);
   import moi_pkg::*;
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic signed [SPEED_BITS-1:0] speed_front_left;
   logic signed [SPEED_BITS-1:0] speed_front_right;
   logic signed [SPEED_BITS-1:0] speed_rear_right;
   logic signed [SPEED_BITS-1:0] speed_rear_left;
   logic [HEAD_BITS-1:0]         heading;

   modport source (output valid, kind, speed_front_left, speed_front_right,
                   speed_rear_right, speed_rear_left, heading, input ready);
   modport sink   (input valid, kind, speed_front_left, speed_front_right,
                   speed_rear_right, speed_rear_left, heading, output ready);
endinterface

interface moi_rsp_if #(parameter int SPEED_BITS = 16, parameter int POS_BITS = 56);
   import moi_pkg::*;
   logic                           valid;
   logic                           ready;
   logic signed [POS_BITS-1:0]     pos_x;
   logic signed [POS_BITS-1:0]     pos_y;
   logic signed [SPEED_BITS+1:0]   vel_x;
   logic signed [SPEED_BITS+1:0]   vel_y;
   logic signed [SPEED_BITS+1:0]   rot_w;
   logic [HEAD_BITS-1:0]           heading_out;

   modport source (output valid, pos_x, pos_y, vel_x, vel_y, rot_w, heading_out,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, rot_w, heading_out,
                   output ready);
endinterface

interface moi_csr_if;
   import moi_pkg::*;
   logic               valid;
   logic               ready;
   logic [IV_BITS-1:0] interval_us;

   modport source (output valid, interval_us, input ready);
   modport sink   (input valid, interval_us, output ready);
endinterface

// ===== rtl/moi_cordic.sv =====
// Iterative rotation-mode CORDIC producing clamped cosine and sine of a heading.
module moi_cordic #(
   parameter int TRIG_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [moi_pkg::HEAD_BITS-1:0]     heading,
   output logic                              done,
   output logic signed [TRIG_BITS-1:0]       cos_q,
   output logic signed [TRIG_BITS-1:0]       sin_q
);
   import moi_pkg::*;

   localparam int XW = 34;
   localparam int ZW = ANGLE_BITS + 1;
   localparam int RS = 31 - TRIG_BITS;
   localparam logic signed [XW-1:0] RND  = XW'(1) << (RS - 1);
   localparam logic signed [XW-1:0] TMAX = (XW'(1) << (TRIG_BITS - 1)) - XW'(1);
   localparam logic signed [XW-1:0] TMIN = -TMAX - XW'(1);

   typedef enum logic [2:0] {
      C_IDLE  = 3'b001,
      C_ITER  = 3'b010,
      C_ROUND = 3'b100
   } moi_cordic_state_type;

   moi_cordic_state_type       state_ff, state_in;
   logic [STEP_BITS-1:0]       iter_ff, iter_in;
   logic signed [XW-1:0]       x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0]       z_ff, z_in;
   logic                       flip_ff, flip_in;
   logic                       done_ff, done_in;
   logic signed [TRIG_BITS-1:0] cos_ff, cos_in, sin_ff, sin_in;

   logic signed [XW-1:0]         xs, ys, rx, ry;
   logic signed [ZW-1:0]         ang;
   logic signed [ANGLE_BITS-1:0] z0;

   assign xs  = x_ff >>> iter_ff;
   assign ys  = y_ff >>> iter_ff;
   assign ang = signed'({1'b0, atan_step(iter_ff)});
   assign z0  = {heading[HEAD_BITS-2], heading[HEAD_BITS-2:0],
                 {(ANGLE_BITS-HEAD_BITS){1'b0}}};

   always_comb begin
      rx = (x_ff + RND) >>> RS;
      ry = (y_ff + RND) >>> RS;
      if (flip_ff) begin
         rx = -rx;
         ry = -ry;
      end
   end

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      flip_in  = flip_ff;
      done_in  = 1'b0;
      cos_in   = cos_ff;
      sin_in   = sin_ff;
      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               x_in     = XW'(CORDIC_GAIN);
               y_in     = '0;
               z_in     = ZW'(z0);
               flip_in  = heading[HEAD_BITS-1] ^ heading[HEAD_BITS-2];
               iter_in  = '0;
               state_in = C_ITER;
            end
         end
         C_ITER: begin
            if (!z_ff[ZW-1]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - ang;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + ang;
            end
            if (iter_ff == STEP_BITS'(CORDIC_STEPS - 1)) begin
               state_in = C_ROUND;
            end else begin
               iter_in = iter_ff + 1'b1;
            end
         end
         C_ROUND: begin
            cos_in   = (rx > TMAX) ? TMAX[TRIG_BITS-1:0] :
                       (rx < TMIN) ? TMIN[TRIG_BITS-1:0] : rx[TRIG_BITS-1:0];
            sin_in   = (ry > TMAX) ? TMAX[TRIG_BITS-1:0] :
                       (ry < TMIN) ? TMIN[TRIG_BITS-1:0] : ry[TRIG_BITS-1:0];
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff <= iter_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
   end

   assign done  = done_ff;
   assign cos_q = cos_ff;
   assign sin_q = sin_ff;

endmodule

// ===== rtl/moi_mulacc.sv =====
// Shared signed multiplier with a registered product and a clear/add/subtract accumulator.
module moi_mulacc #(
   parameter int A_BITS = 20,
   parameter int B_BITS = 17
) (
   input  logic                             clock,
   input  logic                             reset,
   input  moi_pkg::moi_mul_ctl_type         ctl,
   input  logic signed [A_BITS-1:0]         a,
   input  logic signed [B_BITS-1:0]         b,
   output logic signed [A_BITS+B_BITS-1:0]  acc
);
   import moi_pkg::*;

   localparam int PW = A_BITS + B_BITS;

   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [PW-1:0] acc_ff, acc_in;
   moi_mul_ctl_type      ctl_d_ff;
   logic signed [PW-1:0] base;

   assign prod_in = ctl.issue ? a * b : prod_ff;

   always_comb begin
      base   = ctl_d_ff.first ? '0 : acc_ff;
      acc_in = acc_ff;
      if (ctl_d_ff.issue) begin
         acc_in = ctl_d_ff.sub ? base - prod_ff : base + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_d_ff <= '0;
      end else begin
         ctl_d_ff <= ctl;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ===== rtl/mecanum_odometry_integrator_top.sv =====
// Top level of the mecanum odometry integrator: sequencer, state and response register.
//
//   channel  dir  payload                                          transfer
//   req_ch   in   kind, four wheel speeds, heading                 valid & ready
//   rsp_ch   out  pos_x, pos_y, vel_x, vel_y, rot_w, heading_out   valid & ready
//   csr_ch   in   interval_us                                      valid & ready
//
// An update passes through the iterative CORDIC unit, the shared multiplier schedule
// and the finish steps before the next request can be taken. A reset item goes
// straight to the finish step. req_ch.ready is high only while the sequencer idles.
// A response waits in its own register; a full register stalls only the finish step.
// Synchronous reset clears position, velocities, heading and sets interval_us to 10000.
module mecanum_odometry_integrator_top #(
   parameter int SPEED_BITS = 16,
   parameter int POS_BITS   = 56,
   parameter int TRIG_BITS  = 16
) (
   input  logic         clock,
   input  logic         reset,
   moi_req_if.sink      req_ch,
   moi_rsp_if.source    rsp_ch,
   moi_csr_if.sink      csr_ch
);
   import moi_pkg::*;

   localparam int VB = SPEED_BITS + 2;
   localparam int MA = VB + 2;
   localparam int MB = (TRIG_BITS > IV_BITS + 1) ? TRIG_BITS : IV_BITS + 1;
   localparam int PW = MA + MB;
   localparam int SW = ((POS_BITS > PW) ? POS_BITS : PW) + 1;

   localparam logic signed [PW-1:0] RX_RND = PW'(1) << (TRIG_BITS - 2);
   localparam logic signed [SW-1:0] PMAX   = (SW'(1) << (POS_BITS - 1)) - SW'(1);
   localparam logic signed [SW-1:0] PMIN   = -PMAX - SW'(1);

   localparam logic [2:0] ST_VXC = 3'd0;
   localparam logic [2:0] ST_VYS = 3'd1;
   localparam logic [2:0] ST_VYC = 3'd2;
   localparam logic [2:0] ST_VXS = 3'd3;
   localparam logic [2:0] ST_RXI = 3'd4;
   localparam logic [2:0] ST_RYH = 3'd5;
   localparam logic [2:0] ST_RYI = 3'd6;
   localparam logic [2:0] ST_END = 3'd7;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_TRIG = 5'b00010,
      S_MUL  = 5'b00100,
      S_ACCY = 5'b01000,
      S_DONE = 5'b10000
   } moi_state_type;

   moi_state_type            state_ff, state_in;
   logic [2:0]               step_ff, step_in;
   logic [IV_BITS-1:0]       interval_ff, interval_in;
   logic signed [POS_BITS-1:0] world_x_ff, world_x_in, world_y_ff, world_y_in;
   logic signed [VB-1:0]     body_vx_ff, body_vx_in, body_vy_ff, body_vy_in;
   logic signed [VB-1:0]     body_w_ff, body_w_in;
   logic [HEAD_BITS-1:0]     heading_ff, heading_in;
   logic signed [MA-1:0]     rx_ff, rx_in, ry_ff, ry_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [POS_BITS-1:0] rsp_pos_x_ff, rsp_pos_x_in, rsp_pos_y_ff, rsp_pos_y_in;
   logic signed [VB-1:0]     rsp_vel_x_ff, rsp_vel_x_in, rsp_vel_y_ff, rsp_vel_y_in;
   logic signed [VB-1:0]     rsp_rot_w_ff, rsp_rot_w_in;
   logic [HEAD_BITS-1:0]     rsp_heading_ff, rsp_heading_in;

   logic                     req_fire;
   logic                     rsp_load;
   logic                     cordic_start;
   logic                     cordic_done;
   logic signed [TRIG_BITS-1:0] cos_q, sin_q;
   moi_mul_ctl_type          mul_ctl;
   logic signed [MA-1:0]     mul_a;
   logic signed [MB-1:0]     mul_b;
   logic signed [MB-1:0]     iv_op;
   logic signed [PW-1:0]     acc;
   logic signed [PW-1:0]     rsum;
   logic signed [SW-1:0]     sat_sum;
   logic signed [POS_BITS-1:0] sat_base, sat_out;
   logic signed [VB-1:0]     s1, s2, s3, s4;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign rsp_load     = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ch.ready);
   assign cordic_start = req_fire && !req_ch.kind;

   assign s1 = VB'(req_ch.speed_front_left);
   assign s2 = VB'(req_ch.speed_front_right);
   assign s3 = VB'(req_ch.speed_rear_right);
   assign s4 = VB'(req_ch.speed_rear_left);

   moi_cordic #(
      .TRIG_BITS (TRIG_BITS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .heading (req_ch.heading),
      .done    (cordic_done),
      .cos_q   (cos_q),
      .sin_q   (sin_q)
   );

   moi_mulacc #(
      .A_BITS (MA),
      .B_BITS (MB)
   ) u_mulacc (
      .clock (clock),
      .reset (reset),
      .ctl   (mul_ctl),
      .a     (mul_a),
      .b     (mul_b),
      .acc   (acc)
   );

   assign iv_op = MB'(signed'({1'b0, interval_ff}));

   always_comb begin
      mul_ctl = '0;
      mul_a   = '0;
      mul_b   = '0;
      if (state_ff == S_MUL) begin
         unique case (step_ff)
            ST_VXC: begin
               mul_ctl = '{issue: 1'b1, first: 1'b1, sub: 1'b0};
               mul_a   = MA'(body_vx_ff);
               mul_b   = MB'(cos_q);
            end
            ST_VYS: begin
               mul_ctl = '{issue: 1'b1, first: 1'b0, sub: 1'b0};
               mul_a   = MA'(body_vy_ff);
               mul_b   = MB'(sin_q);
            end
            ST_VYC: begin
               mul_ctl = '{issue: 1'b1, first: 1'b1, sub: 1'b0};
               mul_a   = MA'(body_vy_ff);
               mul_b   = MB'(cos_q);
            end
            ST_VXS: begin
               mul_ctl = '{issue: 1'b1, first: 1'b0, sub: 1'b1};
               mul_a   = MA'(body_vx_ff);
               mul_b   = MB'(sin_q);
            end
            ST_RXI: begin
               mul_ctl = '{issue: 1'b1, first: 1'b1, sub: 1'b0};
               mul_a   = rx_ff;
               mul_b   = iv_op;
            end
            ST_RYI: begin
               mul_ctl = '{issue: 1'b1, first: 1'b1, sub: 1'b0};
               mul_a   = ry_ff;
               mul_b   = iv_op;
            end
            default: mul_ctl = '0;
         endcase
      end
   end

   assign rsum     = (acc + RX_RND) >>> (TRIG_BITS - 1);
   assign sat_base = (state_ff == S_ACCY) ? world_y_ff : world_x_ff;
   assign sat_sum  = SW'(sat_base) + SW'(acc);
   assign sat_out  = (sat_sum > PMAX) ? PMAX[POS_BITS-1:0] :
                     (sat_sum < PMIN) ? PMIN[POS_BITS-1:0] : sat_sum[POS_BITS-1:0];

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      interval_in    = interval_ff;
      world_x_in     = world_x_ff;
      world_y_in     = world_y_ff;
      body_vx_in     = body_vx_ff;
      body_vy_in     = body_vy_ff;
      body_w_in      = body_w_ff;
      heading_in     = heading_ff;
      rx_in          = rx_ff;
      ry_in          = ry_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_pos_x_in   = rsp_pos_x_ff;
      rsp_pos_y_in   = rsp_pos_y_ff;
      rsp_vel_x_in   = rsp_vel_x_ff;
      rsp_vel_y_in   = rsp_vel_y_ff;
      rsp_rot_w_in   = rsp_rot_w_ff;
      rsp_heading_in = rsp_heading_ff;

      if (csr_ch.valid && csr_ch.ready) begin
         interval_in = csr_ch.interval_us;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_ch.kind) begin
                  world_x_in = '0;
                  world_y_in = '0;
                  body_vx_in = '0;
                  body_vy_in = '0;
                  body_w_in  = '0;
                  heading_in = '0;
                  state_in   = S_DONE;
               end else begin
                  body_vy_in = s1 + s2 + s3 + s4;
                  body_vx_in = s1 - s2 + s3 - s4;
                  body_w_in  = s1 - s2 - s3 + s4;
                  heading_in = req_ch.heading;
                  state_in   = S_TRIG;
               end
            end
         end
         S_TRIG: begin
            if (cordic_done) begin
               step_in  = ST_VXC;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            step_in = step_ff + 1'b1;
            if (step_ff == ST_VXS) begin
               rx_in = rsum[MA-1:0];
            end
            if (step_ff == ST_RYH) begin
               ry_in = rsum[MA-1:0];
            end
            if (step_ff == ST_RYI) begin
               world_x_in = sat_out;
            end
            if (step_ff == ST_END) begin
               state_in = S_ACCY;
            end
         end
         S_ACCY: begin
            world_y_in = sat_out;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in   = 1'b1;
               rsp_pos_x_in   = world_x_ff;
               rsp_pos_y_in   = world_y_ff;
               rsp_vel_x_in   = body_vx_ff;
               rsp_vel_y_in   = body_vy_ff;
               rsp_rot_w_in   = body_w_ff;
               rsp_heading_in = heading_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= ST_VXC;
         interval_ff  <= INTERVAL_RESET;
         world_x_ff   <= '0;
         world_y_ff   <= '0;
         body_vx_ff   <= '0;
         body_vy_ff   <= '0;
         body_w_ff    <= '0;
         heading_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         interval_ff  <= interval_in;
         world_x_ff   <= world_x_in;
         world_y_ff   <= world_y_in;
         body_vx_ff   <= body_vx_in;
         body_vy_ff   <= body_vy_in;
         body_w_ff    <= body_w_in;
         heading_ff   <= heading_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rx_ff          <= rx_in;
      ry_ff          <= ry_in;
      rsp_pos_x_ff   <= rsp_pos_x_in;
      rsp_pos_y_ff   <= rsp_pos_y_in;
      rsp_vel_x_ff   <= rsp_vel_x_in;
      rsp_vel_y_ff   <= rsp_vel_y_in;
      rsp_rot_w_ff   <= rsp_rot_w_in;
      rsp_heading_ff <= rsp_heading_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.pos_x       = rsp_pos_x_ff;
   assign rsp_ch.pos_y       = rsp_pos_y_ff;
   assign rsp_ch.vel_x       = rsp_vel_x_ff;
   assign rsp_ch.vel_y       = rsp_vel_y_ff;
   assign rsp_ch.rot_w       = rsp_rot_w_ff;
   assign rsp_ch.heading_out = rsp_heading_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ch.ready)
      else $error("request taken while an item is in flight");

   a_clear_item: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_ch.kind |=> (world_x_ff == '0) && (world_y_ff == '0) &&
                                  (body_vx_ff == '0) && (heading_ff == '0))
      else $error("reset item left state behind");

   a_mul_in_schedule: assert property (@(posedge clock) disable iff (reset)
      mul_ctl.issue |-> (state_ff == S_MUL))
      else $error("multiplier issued outside its schedule");

   a_cordic_owner: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> (state_ff == S_TRIG))
      else $error("trig result arrived with no one waiting");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_ch.valid && (state_ff == S_IDLE))
      else $error("finished item did not reach the response register");

endmodule
